// ===== src/pngu_pkg.sv =====
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types, constants and the paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package pngu_pkg;

  localparam int BYTE_W     = 8;
  localparam int CFG_DATA_W = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int LINE_CFG_W = 14;
  localparam int PIX_CFG_W  = 4;

  localparam logic [LINE_CFG_W-1:0] LINE_BYTES_RESET  = 14'd5;
  localparam logic [PIX_CFG_W-1:0]  PIXEL_BYTES_RESET = 4'd4;
  localparam logic [LINE_CFG_W-1:0] LINE_BYTES_MIN    = 14'd2;

  // configuration register index
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES  = 1'b0,
    CFG_PIXEL_BYTES = 1'b1
  } cfg_reg_t;

  // filter type of a scanline, bad marks a type byte above paeth
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4,
    FILT_BAD   = 3'd5
  } filt_t;

  // per-item control handed from the column control to the datapath
  typedef struct packed {
    filt_t filt;
    logic  left_ok;
    logic  above_ok;
    logic  last;
  } data_tag_t;

  function automatic logic [BYTE_W-1:0] paeth(
    input logic [BYTE_W-1:0] a,
    input logic [BYTE_W-1:0] b,
    input logic [BYTE_W-1:0] c
  );
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W:0]   ab;
    logic [BYTE_W:0]   c2;
    logic [BYTE_W:0]   pc;
    logic [BYTE_W-1:0] res;
    pa = (b > c) ? (b - c) : (c - b);
    pb = (a > c) ? (a - c) : (c - a);
    ab = {1'b0, a} + {1'b0, b};
    c2 = {c, 1'b0};
    pc = (ab > c2) ? (ab - c2) : (c2 - ab);
    if (({1'b0, pa} <= {1'b0, pb}) && ({1'b0, pa} <= pc)) begin
      res = a;
    end else if ({1'b0, pb} <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

// ===== src/pngu_if.sv =====
// ----------------------------------------------------------------------------
// pngu_if
// Valid/ready channels for the filtered byte stream and the pixel stream.
// ----------------------------------------------------------------------------
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] coded_byte;
  logic       image_start;

  modport source (output valid, output coded_byte, output image_start, input ready);
  modport sink (input valid, input coded_byte, input image_start, output ready);
endinterface

interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       line_end;
  logic       bad_filter;

  modport source (output valid, output pixel_byte, output line_end, output bad_filter,
                  input ready);
  modport sink (input valid, input pixel_byte, input line_end, input bad_filter,
                output ready);
endinterface

// ===== src/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG filter reconstruction (none, sub, up, average, paeth) on a byte stream.
// ----------------------------------------------------------------------------
// The block takes one filtered byte per cycle and sustains one item per cycle
// with no bubbles while the output is ready, also across scanline and image
// boundaries. The first byte of each scanline is the filter type and gives no
// result; every later byte gives one reconstructed pixel byte through input
// side column control, one reconstruction stage and the output register.
// The previous row lives in one synchronous memory of MAX_LINE_BYTES bytes,
// read while a byte is accepted and written back when its result is formed,
// so one read and one write per cycle set the rate; a write and read of the
// same entry on one edge is covered by forwarding. The row memory powers up
// undefined and has no clearing pass: rows above the first of an image are
// always written before they are read. Filter types above four pass the data
// bytes of that line raw with bad_filter set. The user must write configuration
// (line_bytes, pixel_bytes) only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
  parameter int MAX_LINE_BYTES  = 8192,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pngu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]   cfg_data,
  pngu_in_if.sink                           in_ch,
  pngu_out_if.source                        out_ch
);

  // row memory address and history select widths
  localparam int AW = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic                           acc;
  logic                           data_go;
  logic                           hold;
  logic [AW-1:0]                  rd_addr;
  logic [pngu_pkg::BYTE_W-1:0]    rd_data;
  pngu_pkg::data_tag_t            tag;
  logic [PW-1:0]                  left_sel;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  logic [pngu_pkg::BYTE_W-1:0]    wr_data;

  // stall only while the reconstruction stage holds an item it cannot pass on
  assign in_ch.ready = !hold;
  assign acc         = in_ch.valid && in_ch.ready;

  // column count, row flags, filter type and configuration registers
  pngu_ctrl #(
    .MAX_LINE_BYTES  (MAX_LINE_BYTES),
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .AW              (AW),
    .PW              (PW)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .acc           (acc),
    .coded_byte    (in_ch.coded_byte),
    .image_start   (in_ch.image_start),
    .data_go       (data_go),
    .rd_addr       (rd_addr),
    .tag           (tag),
    .left_sel      (left_sel)
  );

  // previous row, read at accept, written back at reconstruction
  pngu_row_mem #(
    .DEPTH (MAX_LINE_BYTES),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (data_go),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // predictor, left and above-left histories, output register
  pngu_recon #(
    .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
    .AW              (AW),
    .PW              (PW)
  ) u_recon (
    .clk           (clk),
    .rst           (rst),
    .data_go       (data_go),
    .coded_byte    (in_ch.coded_byte),
    .rd_addr       (rd_addr),
    .tag           (tag),
    .left_sel      (left_sel),
    .rd_data       (rd_data),
    .hold          (hold),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .out_ch        (out_ch)
  );

endmodule

// ===== src/pngu_row_mem.sv =====
// ----------------------------------------------------------------------------
// pngu_row_mem
// Previous-row store, one write and one registered read port.
// ----------------------------------------------------------------------------
module pngu_row_mem #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [pngu_pkg::BYTE_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [pngu_pkg::BYTE_W-1:0]   wr_data
);

  logic [pngu_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/pngu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pngu_ctrl
// Configuration registers and column/row tracking at the input side.
// ----------------------------------------------------------------------------
module pngu_ctrl #(
  parameter int MAX_LINE_BYTES  = 8192,
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int AW              = 13,
  parameter int PW              = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pngu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pngu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                acc,
  input  logic [pngu_pkg::BYTE_W-1:0]         coded_byte,
  input  logic                                image_start,
  output logic                                data_go,
  output logic [AW-1:0]                       rd_addr,
  output pngu_pkg::data_tag_t                 tag,
  output logic [PW-1:0]                       left_sel
);

  localparam int LW   = $clog2(MAX_LINE_BYTES + 1);
  localparam int LenW = ($clog2(MAX_LINE_BYTES + 2) > pngu_pkg::LINE_CFG_W) ?
                        $clog2(MAX_LINE_BYTES + 2) : pngu_pkg::LINE_CFG_W;
  localparam int CmpW = (AW > pngu_pkg::PIX_CFG_W) ? AW : pngu_pkg::PIX_CFG_W;
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_LINE_BYTES + 1);
  localparam logic [pngu_pkg::PIX_CFG_W-1:0] BppMax = pngu_pkg::PIX_CFG_W'(MAX_PIXEL_BYTES);

  logic [LW-1:0]                       column;
  logic [LW-1:0]                       column_next;
  logic                                past_first;
  logic                                past_first_next;
  pngu_pkg::filt_t                     row_filter;
  pngu_pkg::filt_t                     row_filter_next;
  logic [pngu_pkg::LINE_CFG_W-1:0]     line_bytes;
  logic [pngu_pkg::PIX_CFG_W-1:0]      pixel_bytes;

  logic [LW-1:0]                       col_eff;
  logic                                is_type;
  logic [LW-1:0]                       d_full;
  logic [pngu_pkg::PIX_CFG_W-1:0]      bpp;
  logic [LenW-1:0]                     len;
  logic                                last;

  always_comb begin
    col_eff = image_start ? '0 : column;
    is_type = (col_eff == '0);
    d_full  = col_eff - LW'(1);

    if (pixel_bytes == '0) begin
      bpp = pngu_pkg::PIX_CFG_W'(1);
    end else if (pixel_bytes > BppMax) begin
      bpp = BppMax;
    end else begin
      bpp = pixel_bytes;
    end

    if (line_bytes < pngu_pkg::LINE_BYTES_MIN) begin
      len = LenW'(pngu_pkg::LINE_BYTES_MIN);
    end else if (LenW'(line_bytes) > LenMax) begin
      len = LenMax;
    end else begin
      len = LenW'(line_bytes);
    end

    last = (LenW'(col_eff) >= (len - LenW'(1)));

    data_go  = acc && !is_type;
    rd_addr  = d_full[AW-1:0];
    left_sel = PW'(bpp - pngu_pkg::PIX_CFG_W'(1));

    tag.filt     = row_filter;
    tag.left_ok  = (CmpW'(d_full[AW-1:0]) >= CmpW'(bpp));
    tag.above_ok = past_first;
    tag.last     = last;

    column_next     = column;
    past_first_next = past_first;
    row_filter_next = row_filter;
    if (acc) begin
      if (is_type) begin
        column_next = LW'(1);
        if (image_start) begin
          past_first_next = 1'b0;
        end
        if (coded_byte > pngu_pkg::BYTE_W'(pngu_pkg::FILT_PAETH)) begin
          row_filter_next = pngu_pkg::FILT_BAD;
        end else begin
          row_filter_next = pngu_pkg::filt_t'(coded_byte[2:0]);
        end
      end else if (last) begin
        column_next     = '0;
        past_first_next = 1'b1;
      end else begin
        column_next = column + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      past_first  <= 1'b0;
      row_filter  <= pngu_pkg::FILT_NONE;
      line_bytes  <= pngu_pkg::LINE_BYTES_RESET;
      pixel_bytes <= pngu_pkg::PIXEL_BYTES_RESET;
    end else begin
      column     <= column_next;
      past_first <= past_first_next;
      row_filter <= row_filter_next;
      if (cfg_we) begin
        case (pngu_pkg::cfg_reg_t'(cfg_index))
          pngu_pkg::CFG_LINE_BYTES:  line_bytes  <= cfg_data[pngu_pkg::LINE_CFG_W-1:0];
          pngu_pkg::CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[pngu_pkg::PIX_CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== src/pngu_recon.sv =====
// ----------------------------------------------------------------------------
// pngu_recon
// Reconstruction stage: predictor, pixel histories, row write-back, output.
// ----------------------------------------------------------------------------
module pngu_recon #(
  parameter int MAX_PIXEL_BYTES = 8,
  parameter int AW              = 13,
  parameter int PW              = 3
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            data_go,
  input  logic [pngu_pkg::BYTE_W-1:0]     coded_byte,
  input  logic [AW-1:0]                   rd_addr,
  input  pngu_pkg::data_tag_t             tag,
  input  logic [PW-1:0]                   left_sel,
  input  logic [pngu_pkg::BYTE_W-1:0]     rd_data,
  output logic                            hold,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [pngu_pkg::BYTE_W-1:0]     wr_data,
  pngu_out_if.source                      out_ch
);

  localparam int BW = pngu_pkg::BYTE_W;

  logic                  s1_valid;
  logic [BW-1:0]         s1_fb;
  logic [AW-1:0]         s1_d;
  pngu_pkg::data_tag_t   s1_tag;
  logic                  s1_fwd;
  logic                  s1_go;

  logic [BW-1:0]         left_hist  [MAX_PIXEL_BYTES];
  logic [BW-1:0]         above_hist [MAX_PIXEL_BYTES];

  logic                  out_valid;
  logic [BW-1:0]         pixel_byte;
  logic                  line_end;
  logic                  bad_filter;

  logic [BW-1:0]         above_raw;
  logic [BW-1:0]         above;
  logic [BW-1:0]         left;
  logic [BW-1:0]         upper_left;
  logic [BW:0]           avg_sum;
  logic [BW-1:0]         pred;
  logic [BW-1:0]         val;

  always_comb begin
    s1_go = s1_valid && (!out_valid || out_ch.ready);
    hold  = s1_valid && !s1_go;

    // same entry written on the edge that read it: take the value just committed
    above_raw  = s1_fwd ? left_hist[0] : rd_data;
    above      = s1_tag.above_ok ? above_raw : '0;
    left       = s1_tag.left_ok ? left_hist[left_sel] : '0;
    upper_left = (s1_tag.left_ok && s1_tag.above_ok) ? above_hist[left_sel] : '0;
    avg_sum    = {1'b0, left} + {1'b0, above};

    case (s1_tag.filt)
      pngu_pkg::FILT_SUB:   pred = left;
      pngu_pkg::FILT_UP:    pred = above;
      pngu_pkg::FILT_AVG:   pred = avg_sum[BW:1];
      pngu_pkg::FILT_PAETH: pred = pngu_pkg::paeth(left, above, upper_left);
      default:              pred = '0;
    endcase
    val = s1_fb + pred;

    wr_en   = s1_go;
    wr_addr = s1_d;
    wr_data = val;

    out_ch.valid      = out_valid;
    out_ch.pixel_byte = pixel_byte;
    out_ch.line_end   = line_end;
    out_ch.bad_filter = bad_filter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (data_go) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (data_go) begin
      s1_fb  <= coded_byte;
      s1_d   <= rd_addr;
      s1_tag <= tag;
      s1_fwd <= s1_valid && (s1_d == rd_addr);
    end
    if (s1_go) begin
      pixel_byte <= val;
      line_end   <= s1_tag.last;
      bad_filter <= (s1_tag.filt == pngu_pkg::FILT_BAD);
    end
  end

  // history entries are read only once the current line has filled them
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= '0;
        above_hist[i] <= '0;
      end
    end else if (s1_go) begin
      left_hist[0]  <= val;
      above_hist[0] <= above;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= left_hist[i-1];
        above_hist[i] <= above_hist[i-1];
      end
    end
  end

endmodule
